// File: rtl/qpcm_pkg.sv
// Shared types and constants for the quad perspective coordinate map.
// Holds field widths, status codes, register indexes and the coefficient bundle.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package qpcm_pkg;

    localparam int FRAC_BITS_DEFAULT = 16;
    localparam int UV_W              = 17;
    localparam int UV_FRAC           = 16;
    localparam int COORD_W           = 32;
    localparam int STATUS_W          = 2;
    localparam int IDX_W             = 4;
    localparam int NUM_CORNER_REGS   = 8;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 64;

    // Widths of the homography terms, all scaled by the corner determinant.
    localparam int DET_W   = 67;
    localparam int GH_W    = 68;
    localparam int AD_W    = 102;
    localparam int DS_W    = 84;
    localparam int ODET_W  = 100;
    localparam int OFS_W   = 116;
    localparam int PIECE_W = 34;
    localparam int PROD_W  = 53;
    localparam int SUM_W   = 128;

    // Rounded division: 33 quotient bits plus an overflow flag.
    localparam int QBITS = 33;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_DEGEN = 2'd1,
        STATUS_SAT   = 2'd2
    } map_status_t;

    typedef enum logic [IDX_W-1:0] {
        REG_C0X = 4'd0,
        REG_C0Y = 4'd1,
        REG_C1X = 4'd2,
        REG_C1Y = 4'd3,
        REG_C2X = 4'd4,
        REG_C2Y = 4'd5,
        REG_C3X = 4'd6,
        REG_C3Y = 4'd7
    } cfg_reg_t;

    typedef struct packed {
        logic signed [GH_W-1:0]  g;
        logic signed [GH_W-1:0]  h;
        logic signed [AD_W-1:0]  a;
        logic signed [AD_W-1:0]  b;
        logic signed [AD_W-1:0]  c;
        logic signed [AD_W-1:0]  d;
        logic signed [DS_W-1:0]  ds;
        logic signed [OFS_W-1:0] x0ds;
        logic signed [OFS_W-1:0] y0ds;
        logic                    det_zero;
    } qpcm_coef_t;

endpackage

`default_nettype wire

// File: rtl/qpcm_coef.sv
// Corner registers and the sequencer that derives the homography coefficients.
// A shift-and-add multiplier works through sixteen signed products in turn.
// Depends on qpcm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qpcm_coef #(
    parameter int COORD_FRAC_BITS = qpcm_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_valid,
    input  wire logic [qpcm_pkg::IDX_W-1:0]   cfg_index,
    input  wire logic [qpcm_pkg::COORD_W-1:0] cfg_data,
    output qpcm_pkg::qpcm_coef_t              coef,
    output logic                              busy
);
    import qpcm_pkg::*;

    localparam int ACC_W     = 128;
    localparam int MPLIER_W  = 72;
    localparam int NSTEPS    = 16;
    localparam int STEP_W    = 4;
    localparam int BCNT_W    = 7;
    localparam int OPND_NUM  = 19;
    localparam int CIDX_W    = $clog2(NUM_CORNER_REGS);

    typedef enum logic [4:0] {
        OPND_DX1, OPND_DY1, OPND_DX2, OPND_DY2, OPND_SX, OPND_SY,
        OPND_X1MX0, OPND_X2MX0, OPND_Y1MX0, OPND_Y2MX0,
        OPND_X0, OPND_Y0, OPND_X1, OPND_X2, OPND_Y1, OPND_Y2,
        OPND_DET, OPND_G, OPND_H
    } opnd_t;

    typedef enum logic [3:0] {
        DST_DET, DST_G, DST_H, DST_A, DST_B, DST_C, DST_D, DST_X0D, DST_Y0D
    } dst_t;

    typedef struct packed {
        opnd_t a_sel;
        opnd_t b_sel;
        logic  sub;
        logic  first;
        logic  last;
        dst_t  dst;
    } step_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LOAD = 3'b010,
        ST_MUL  = 3'b100
    } state_t;

    function automatic step_t mk(input opnd_t a, input opnd_t b, input logic sub,
                                 input logic first, input logic last, input dst_t dst);
        step_t s;
        s.a_sel = a;
        s.b_sel = b;
        s.sub   = sub;
        s.first = first;
        s.last  = last;
        s.dst   = dst;
        return s;
    endfunction

    // Each coefficient is one or two products summed into the accumulator.
    function automatic step_t step_rom(input logic [STEP_W-1:0] k);
        step_t s;
        case (k)
            4'd0:    s = mk(OPND_DX1,   OPND_DY2, 1'b0, 1'b1, 1'b0, DST_DET);
            4'd1:    s = mk(OPND_DX2,   OPND_DY1, 1'b1, 1'b0, 1'b1, DST_DET);
            4'd2:    s = mk(OPND_SX,    OPND_DY2, 1'b0, 1'b1, 1'b0, DST_G);
            4'd3:    s = mk(OPND_DX2,   OPND_SY,  1'b1, 1'b0, 1'b1, DST_G);
            4'd4:    s = mk(OPND_DX1,   OPND_SY,  1'b0, 1'b1, 1'b0, DST_H);
            4'd5:    s = mk(OPND_SX,    OPND_DY1, 1'b1, 1'b0, 1'b1, DST_H);
            4'd6:    s = mk(OPND_X1MX0, OPND_DET, 1'b0, 1'b1, 1'b0, DST_A);
            4'd7:    s = mk(OPND_X1,    OPND_G,   1'b0, 1'b0, 1'b1, DST_A);
            4'd8:    s = mk(OPND_X2MX0, OPND_DET, 1'b0, 1'b1, 1'b0, DST_B);
            4'd9:    s = mk(OPND_X2,    OPND_H,   1'b0, 1'b0, 1'b1, DST_B);
            4'd10:   s = mk(OPND_Y1MX0, OPND_DET, 1'b0, 1'b1, 1'b0, DST_C);
            4'd11:   s = mk(OPND_Y1,    OPND_G,   1'b0, 1'b0, 1'b1, DST_C);
            4'd12:   s = mk(OPND_Y2MX0, OPND_DET, 1'b0, 1'b1, 1'b0, DST_D);
            4'd13:   s = mk(OPND_Y2,    OPND_H,   1'b0, 1'b0, 1'b1, DST_D);
            4'd14:   s = mk(OPND_X0,    OPND_DET, 1'b0, 1'b1, 1'b1, DST_X0D);
            4'd15:   s = mk(OPND_Y0,    OPND_DET, 1'b0, 1'b1, 1'b1, DST_Y0D);
            default: s = mk(OPND_DX1,   OPND_DY2, 1'b0, 1'b1, 1'b0, DST_DET);
        endcase
        return s;
    endfunction

    localparam logic signed [COORD_W-1:0] ONE = COORD_W'(64'd1 << COORD_FRAC_BITS);

    localparam logic [CIDX_W-1:0] I_C0X = CIDX_W'(REG_C0X);
    localparam logic [CIDX_W-1:0] I_C0Y = CIDX_W'(REG_C0Y);
    localparam logic [CIDX_W-1:0] I_C1X = CIDX_W'(REG_C1X);
    localparam logic [CIDX_W-1:0] I_C1Y = CIDX_W'(REG_C1Y);
    localparam logic [CIDX_W-1:0] I_C2X = CIDX_W'(REG_C2X);
    localparam logic [CIDX_W-1:0] I_C2Y = CIDX_W'(REG_C2Y);
    localparam logic [CIDX_W-1:0] I_C3X = CIDX_W'(REG_C3X);
    localparam logic [CIDX_W-1:0] I_C3Y = CIDX_W'(REG_C3Y);

    logic signed [COORD_W-1:0] corner_reg [NUM_CORNER_REGS];

    state_t                    state_reg, state_next;
    logic [STEP_W-1:0]         step_reg, step_next;
    logic [BCNT_W-1:0]         bcnt_reg, bcnt_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [ACC_W-1:0]   mcand_reg, mcand_next;
    logic [MPLIER_W-1:0]       mplier_reg, mplier_next;

    logic signed [DET_W-1:0]   det_reg;
    logic signed [GH_W-1:0]    g_reg, h_reg;
    logic signed [AD_W-1:0]    a_reg, b_reg, c_reg, d_reg;
    logic signed [ODET_W-1:0]  x0det_reg, y0det_reg;

    logic signed [COORD_W:0]   dx1, dy1, dx2, dy2, x1mx0, x2mx0, y1mx0, y2mx0;
    logic signed [COORD_W+1:0] sx, sy;
    logic signed [ACC_W-1:0]   opnd_val [OPND_NUM];
    logic signed [ACC_W-1:0]   term;
    logic                      term_neg;
    logic                      cfg_hit;
    step_t                     cur;

    assign cur     = step_rom(step_reg);
    assign cfg_hit = cfg_valid && (cfg_index <= REG_C3Y);

    assign dx1   = (COORD_W+1)'(corner_reg[I_C1X]) - (COORD_W+1)'(corner_reg[I_C3X]);
    assign dy1   = (COORD_W+1)'(corner_reg[I_C1Y]) - (COORD_W+1)'(corner_reg[I_C3Y]);
    assign dx2   = (COORD_W+1)'(corner_reg[I_C2X]) - (COORD_W+1)'(corner_reg[I_C3X]);
    assign dy2   = (COORD_W+1)'(corner_reg[I_C2Y]) - (COORD_W+1)'(corner_reg[I_C3Y]);
    assign x1mx0 = (COORD_W+1)'(corner_reg[I_C1X]) - (COORD_W+1)'(corner_reg[I_C0X]);
    assign x2mx0 = (COORD_W+1)'(corner_reg[I_C2X]) - (COORD_W+1)'(corner_reg[I_C0X]);
    assign y1mx0 = (COORD_W+1)'(corner_reg[I_C1Y]) - (COORD_W+1)'(corner_reg[I_C0Y]);
    assign y2mx0 = (COORD_W+1)'(corner_reg[I_C2Y]) - (COORD_W+1)'(corner_reg[I_C0Y]);
    assign sx = (COORD_W+2)'(corner_reg[I_C0X]) - (COORD_W+2)'(corner_reg[I_C1X])
              - (COORD_W+2)'(corner_reg[I_C2X]) + (COORD_W+2)'(corner_reg[I_C3X]);
    assign sy = (COORD_W+2)'(corner_reg[I_C0Y]) - (COORD_W+2)'(corner_reg[I_C1Y])
              - (COORD_W+2)'(corner_reg[I_C2Y]) + (COORD_W+2)'(corner_reg[I_C3Y]);

    always_comb begin
        opnd_val[OPND_DX1]   = ACC_W'(dx1);
        opnd_val[OPND_DY1]   = ACC_W'(dy1);
        opnd_val[OPND_DX2]   = ACC_W'(dx2);
        opnd_val[OPND_DY2]   = ACC_W'(dy2);
        opnd_val[OPND_SX]    = ACC_W'(sx);
        opnd_val[OPND_SY]    = ACC_W'(sy);
        opnd_val[OPND_X1MX0] = ACC_W'(x1mx0);
        opnd_val[OPND_X2MX0] = ACC_W'(x2mx0);
        opnd_val[OPND_Y1MX0] = ACC_W'(y1mx0);
        opnd_val[OPND_Y2MX0] = ACC_W'(y2mx0);
        opnd_val[OPND_X0]    = ACC_W'(corner_reg[I_C0X]);
        opnd_val[OPND_Y0]    = ACC_W'(corner_reg[I_C0Y]);
        opnd_val[OPND_X1]    = ACC_W'(corner_reg[I_C1X]);
        opnd_val[OPND_X2]    = ACC_W'(corner_reg[I_C2X]);
        opnd_val[OPND_Y1]    = ACC_W'(corner_reg[I_C1Y]);
        opnd_val[OPND_Y2]    = ACC_W'(corner_reg[I_C2Y]);
        opnd_val[OPND_DET]   = ACC_W'(det_reg);
        opnd_val[OPND_G]     = ACC_W'(g_reg);
        opnd_val[OPND_H]     = ACC_W'(h_reg);
    end

    // The top multiplier bit carries negative weight.
    assign term     = mplier_reg[0] ? mcand_reg : '0;
    assign term_neg = cur.sub ^ (bcnt_reg == BCNT_W'(MPLIER_W - 1));

    always_comb begin
        state_next  = state_reg;
        step_next   = step_reg;
        bcnt_next   = bcnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        case (state_reg)
            ST_IDLE: begin
                state_next = ST_IDLE;
            end
            ST_LOAD: begin
                mcand_next  = opnd_val[cur.a_sel];
                mplier_next = opnd_val[cur.b_sel][MPLIER_W-1:0];
                acc_next    = cur.first ? '0 : acc_reg;
                bcnt_next   = '0;
                state_next  = ST_MUL;
            end
            ST_MUL: begin
                acc_next    = term_neg ? acc_reg - term : acc_reg + term;
                mcand_next  = mcand_reg <<< 1;
                mplier_next = mplier_reg >> 1;
                bcnt_next   = bcnt_reg + 1'b1;
                if (bcnt_reg == BCNT_W'(MPLIER_W - 1)) begin
                    step_next  = step_reg + 1'b1;
                    state_next = (step_reg == STEP_W'(NSTEPS - 1)) ? ST_IDLE : ST_LOAD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        // A register write restarts the whole derivation.
        if (cfg_hit) begin
            state_next = ST_LOAD;
            step_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= ST_LOAD;
            step_reg            <= '0;
            corner_reg[I_C0X]   <= '0;
            corner_reg[I_C0Y]   <= '0;
            corner_reg[I_C1X]   <= ONE;
            corner_reg[I_C1Y]   <= '0;
            corner_reg[I_C2X]   <= '0;
            corner_reg[I_C2Y]   <= ONE;
            corner_reg[I_C3X]   <= ONE;
            corner_reg[I_C3Y]   <= ONE;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (cfg_hit) begin
                corner_reg[cfg_index[CIDX_W-1:0]] <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        bcnt_reg   <= bcnt_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        if (state_reg == ST_MUL && bcnt_reg == BCNT_W'(MPLIER_W - 1) && cur.last) begin
            case (cur.dst)
                DST_DET: det_reg   <= acc_next[DET_W-1:0];
                DST_G:   g_reg     <= acc_next[GH_W-1:0];
                DST_H:   h_reg     <= acc_next[GH_W-1:0];
                DST_A:   a_reg     <= acc_next[AD_W-1:0];
                DST_B:   b_reg     <= acc_next[AD_W-1:0];
                DST_C:   c_reg     <= acc_next[AD_W-1:0];
                DST_D:   d_reg     <= acc_next[AD_W-1:0];
                DST_X0D: x0det_reg <= acc_next[ODET_W-1:0];
                DST_Y0D: y0det_reg <= acc_next[ODET_W-1:0];
                default: det_reg   <= det_reg;
            endcase
        end
    end

    always_comb begin
        coef.g        = g_reg;
        coef.h        = h_reg;
        coef.a        = a_reg;
        coef.b        = b_reg;
        coef.c        = c_reg;
        coef.d        = d_reg;
        coef.ds       = DS_W'(det_reg) <<< UV_FRAC;
        coef.x0ds     = OFS_W'(x0det_reg) <<< UV_FRAC;
        coef.y0ds     = OFS_W'(y0det_reg) <<< UV_FRAC;
        coef.det_zero = (det_reg == '0);
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

`default_nettype wire

// File: rtl/qpcm_div.sv
// Pipelined rounded division of the x and y numerators by w, one quotient bit a stage.
// Applies round to nearest, saturation and the degenerate case.
// Depends on qpcm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qpcm_div (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              en,
    input  wire logic                              in_valid,
    input  wire logic                              in_degen,
    input  wire logic signed [qpcm_pkg::SUM_W-1:0] in_xn,
    input  wire logic signed [qpcm_pkg::SUM_W-1:0] in_yn,
    input  wire logic signed [qpcm_pkg::SUM_W-1:0] in_w,
    output logic                                   out_valid,
    output logic [qpcm_pkg::COORD_W-1:0]           out_x,
    output logic [qpcm_pkg::COORD_W-1:0]           out_y,
    output qpcm_pkg::map_status_t                  out_status
);
    import qpcm_pkg::*;

    localparam logic [QBITS-1:0] LIM_POS = QBITS'(64'h7FFF_FFFF);
    localparam logic [QBITS-1:0] LIM_NEG = QBITS'(64'h8000_0000);

    // Magnitudes and signs.
    logic [SUM_W-1:0] nx_reg, ny_reg, dd_reg;
    logic             negx0_reg, negy0_reg, degen0_reg, vld0_reg;

    // Division stages, index k feeds stage k.
    logic [SUM_W-1:0] rx_reg  [QBITS+1];
    logic [SUM_W-1:0] ry_reg  [QBITS+1];
    logic [SUM_W-1:0] den_reg [QBITS+1];
    logic [QBITS-1:0] qx_reg  [QBITS+1];
    logic [QBITS-1:0] qy_reg  [QBITS+1];
    logic             bigx_reg [QBITS+1];
    logic             bigy_reg [QBITS+1];
    logic             negx_reg [QBITS+1];
    logic             negy_reg [QBITS+1];
    logic             degen_reg [QBITS+1];
    logic             vld_reg  [QBITS+1];

    logic             out_valid_reg;
    logic [COORD_W-1:0] out_x_reg, out_y_reg;
    map_status_t      out_status_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            nx_reg     <= in_xn[SUM_W-1] ? SUM_W'(-in_xn) : SUM_W'(in_xn);
            ny_reg     <= in_yn[SUM_W-1] ? SUM_W'(-in_yn) : SUM_W'(in_yn);
            dd_reg     <= in_w[SUM_W-1]  ? SUM_W'(-in_w)  : SUM_W'(in_w);
            negx0_reg  <= in_xn[SUM_W-1] ^ in_w[SUM_W-1];
            negy0_reg  <= in_yn[SUM_W-1] ^ in_w[SUM_W-1];
            degen0_reg <= in_degen || (in_w == '0);
        end
    end

    // Quotient of (2n + d) / 2d is the magnitude rounded half away from zero.
    always_ff @(posedge aclk) begin
        if (en) begin
            rx_reg[0]    <= (nx_reg << 1) + dd_reg;
            ry_reg[0]    <= (ny_reg << 1) + dd_reg;
            den_reg[0]   <= dd_reg << 1;
            qx_reg[0]    <= '0;
            qy_reg[0]    <= '0;
            bigx_reg[0]  <= 1'b0;
            bigy_reg[0]  <= 1'b0;
            negx_reg[0]  <= negx0_reg;
            negy_reg[0]  <= negy0_reg;
            degen_reg[0] <= degen0_reg;
        end
    end

    for (genvar k = 0; k < QBITS; k++) begin : g_bit
        localparam int SH = QBITS - 1 - k;
        logic [SUM_W-1:0] dsh;
        logic             gex, gey;
        logic             bx, by;

        assign dsh = den_reg[k] << SH;
        assign gex = (rx_reg[k] >= dsh);
        assign gey = (ry_reg[k] >= dsh);

        if (k == 0) begin : g_first
            // A quotient of 2^33 or more saturates whatever the remaining bits.
            assign bx = (rx_reg[k] >= (den_reg[k] << QBITS));
            assign by = (ry_reg[k] >= (den_reg[k] << QBITS));
        end else begin : g_rest
            assign bx = bigx_reg[k];
            assign by = bigy_reg[k];
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rx_reg[k+1]    <= gex ? rx_reg[k] - dsh : rx_reg[k];
                ry_reg[k+1]    <= gey ? ry_reg[k] - dsh : ry_reg[k];
                den_reg[k+1]   <= den_reg[k];
                qx_reg[k+1]    <= {qx_reg[k][QBITS-2:0], gex};
                qy_reg[k+1]    <= {qy_reg[k][QBITS-2:0], gey};
                bigx_reg[k+1]  <= bx;
                bigy_reg[k+1]  <= by;
                negx_reg[k+1]  <= negx_reg[k];
                negy_reg[k+1]  <= negy_reg[k];
                degen_reg[k+1] <= degen_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld0_reg <= 1'b0;
            for (int i = 0; i <= QBITS; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            vld0_reg   <= in_valid;
            vld_reg[0] <= vld0_reg;
            for (int i = 0; i < QBITS; i++) begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end
    end

    logic [QBITS-1:0]   limx, limy, magx, magy;
    logic               satx, saty;
    logic [COORD_W-1:0] resx, resy;

    always_comb begin
        limx = negx_reg[QBITS] ? LIM_NEG : LIM_POS;
        limy = negy_reg[QBITS] ? LIM_NEG : LIM_POS;
        satx = bigx_reg[QBITS] || (qx_reg[QBITS] > limx);
        saty = bigy_reg[QBITS] || (qy_reg[QBITS] > limy);
        magx = satx ? limx : qx_reg[QBITS];
        magy = saty ? limy : qy_reg[QBITS];
        resx = negx_reg[QBITS] ? COORD_W'(-magx) : magx[COORD_W-1:0];
        resy = negy_reg[QBITS] ? COORD_W'(-magy) : magy[COORD_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= vld_reg[QBITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (degen_reg[QBITS]) begin
                out_x_reg      <= '0;
                out_y_reg      <= '0;
                out_status_reg <= STATUS_DEGEN;
            end else begin
                out_x_reg      <= resx;
                out_y_reg      <= resy;
                out_status_reg <= (satx || saty) ? STATUS_SAT : STATUS_OK;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_x      = out_x_reg;
    assign out_y      = out_y_reg;
    assign out_status = out_status_reg;

endmodule

`default_nettype wire

// File: rtl/quad_perspective_coordinate_map.sv
// Top level of the square-to-quad projective coordinate map.
// Instantiates the coefficient sequencer (qpcm_coef) and the divider pipeline (qpcm_div).
// Depends on qpcm_pkg.
`timescale 1ns / 1ps
`default_nettype none

// The block maps a unit-square position (u,v) in Q1.16 onto the quad spanned by the four
// configured corners and returns the source coordinate in signed Q16.16, rounded to
// nearest with ties away from zero. While the output is not stalled and no derivation runs,
// it takes one word per clock and delivers one word per clock; a word passes four input and
// product stages, two stages that form magnitudes and the scaled numerator, 33 stages of the
// quotient pipeline that each settle one bit with one wide compare and subtract, and the
// output register. A stall on the output freezes the whole pipeline, so nothing is lost or
// repeated. The nine homography terms are derived from the corners by a shift-and-add
// sequencer that runs sixteen 72-bit products in turn; it starts after reset and again
// after every corner write, and s_tready stays low until it is done.
// Configuration writes are always taken but must only be issued while the block is idle.
// A zero corner determinant or a zero w yields status 1 with zero coordinates; a
// coordinate outside the 32-bit range is clamped and reported as status 2.
module quad_perspective_coordinate_map #(
    parameter int COORD_FRAC_BITS = qpcm_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // Input words.
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [qpcm_pkg::IN_TDATA_W-1:0]  s_tdata,  // u_pos[16:0], v_pos[33:17]
    // Result words.
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [qpcm_pkg::OUT_TDATA_W-1:0]      m_tdata,  // src_x[31:0], src_y[63:32]
    output logic [qpcm_pkg::STATUS_W-1:0]         m_tuser,  // map_status[1:0]
    // Corner register writes.
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [qpcm_pkg::IDX_W-1:0]       cfg_index,
    input  wire logic [qpcm_pkg::COORD_W-1:0]     cfg_data
);
    import qpcm_pkg::*;

    qpcm_coef_t coef;
    logic       coef_busy;
    logic       adv;

    qpcm_coef #(
        .COORD_FRAC_BITS(COORD_FRAC_BITS)
    ) u_coef (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef      (coef),
        .busy      (coef_busy)
    );

    assign cfg_ready = 1'b1;

    // The whole pipeline moves whenever the output register is free or being emptied.
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv && !coef_busy;

    function automatic logic signed [PIECE_W:0] pc_lo(input logic [PIECE_W-1:0] p);
        return $signed({1'b0, p});
    endfunction

    function automatic logic signed [PIECE_W:0] pc_hi(input logic [PIECE_W-1:0] p);
        return $signed({p[PIECE_W-1], p});
    endfunction

    // Stage 0: input register.
    logic [UV_W-1:0] u_reg, v_reg;
    logic            vld0_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            u_reg <= s_tdata[UV_W-1:0];
            v_reg <= s_tdata[2*UV_W-1:UV_W];
        end
    end

    // Stage 1: coefficient pieces times u or v, each multiply 35 by 18 bits.
    logic signed [UV_W:0]    uu, vv;
    logic signed [PROD_W-1:0] pw_reg [4];
    logic signed [PROD_W-1:0] px_reg [6];
    logic signed [PROD_W-1:0] py_reg [6];
    logic                     vld1_reg;

    assign uu = $signed({1'b0, u_reg});
    assign vv = $signed({1'b0, v_reg});

    always_ff @(posedge aclk) begin
        if (adv) begin
            pw_reg[0] <= pc_lo(coef.g[PIECE_W-1:0]) * uu;
            pw_reg[1] <= pc_hi(coef.g[2*PIECE_W-1:PIECE_W]) * uu;
            pw_reg[2] <= pc_lo(coef.h[PIECE_W-1:0]) * vv;
            pw_reg[3] <= pc_hi(coef.h[2*PIECE_W-1:PIECE_W]) * vv;
            px_reg[0] <= pc_lo(coef.a[PIECE_W-1:0]) * uu;
            px_reg[1] <= pc_lo(coef.a[2*PIECE_W-1:PIECE_W]) * uu;
            px_reg[2] <= pc_hi(coef.a[3*PIECE_W-1:2*PIECE_W]) * uu;
            px_reg[3] <= pc_lo(coef.b[PIECE_W-1:0]) * vv;
            px_reg[4] <= pc_lo(coef.b[2*PIECE_W-1:PIECE_W]) * vv;
            px_reg[5] <= pc_hi(coef.b[3*PIECE_W-1:2*PIECE_W]) * vv;
            py_reg[0] <= pc_lo(coef.c[PIECE_W-1:0]) * uu;
            py_reg[1] <= pc_lo(coef.c[2*PIECE_W-1:PIECE_W]) * uu;
            py_reg[2] <= pc_hi(coef.c[3*PIECE_W-1:2*PIECE_W]) * uu;
            py_reg[3] <= pc_lo(coef.d[PIECE_W-1:0]) * vv;
            py_reg[4] <= pc_lo(coef.d[2*PIECE_W-1:PIECE_W]) * vv;
            py_reg[5] <= pc_hi(coef.d[3*PIECE_W-1:2*PIECE_W]) * vv;
        end
    end

    // Stage 2: reassemble each full product from its pieces.
    logic signed [SUM_W-1:0] gu_reg, hv_reg, au_reg, bv_reg, cu_reg, dv_reg;
    logic                    vld2_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            gu_reg <= SUM_W'(pw_reg[0]) + (SUM_W'(pw_reg[1]) <<< PIECE_W);
            hv_reg <= SUM_W'(pw_reg[2]) + (SUM_W'(pw_reg[3]) <<< PIECE_W);
            au_reg <= SUM_W'(px_reg[0]) + (SUM_W'(px_reg[1]) <<< PIECE_W)
                    + (SUM_W'(px_reg[2]) <<< (2 * PIECE_W));
            bv_reg <= SUM_W'(px_reg[3]) + (SUM_W'(px_reg[4]) <<< PIECE_W)
                    + (SUM_W'(px_reg[5]) <<< (2 * PIECE_W));
            cu_reg <= SUM_W'(py_reg[0]) + (SUM_W'(py_reg[1]) <<< PIECE_W)
                    + (SUM_W'(py_reg[2]) <<< (2 * PIECE_W));
            dv_reg <= SUM_W'(py_reg[3]) + (SUM_W'(py_reg[4]) <<< PIECE_W)
                    + (SUM_W'(py_reg[5]) <<< (2 * PIECE_W));
        end
    end

    // Stage 3: w and the two numerators, all scaled by the determinant.
    logic signed [SUM_W-1:0] w_reg, xn_reg, yn_reg;
    logic                    dz3_reg, vld3_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            w_reg   <= gu_reg + hv_reg + SUM_W'(coef.ds);
            xn_reg  <= au_reg + bv_reg + SUM_W'(coef.x0ds);
            yn_reg  <= cu_reg + dv_reg + SUM_W'(coef.y0ds);
            dz3_reg <= coef.det_zero;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld0_reg <= 1'b0;
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end else if (adv) begin
            vld0_reg <= s_tvalid && !coef_busy;
            vld1_reg <= vld0_reg;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    logic [COORD_W-1:0] src_x, src_y;
    map_status_t        map_status;

    qpcm_div u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (adv),
        .in_valid   (vld3_reg),
        .in_degen   (dz3_reg),
        .in_xn      (xn_reg),
        .in_yn      (yn_reg),
        .in_w       (w_reg),
        .out_valid  (m_tvalid),
        .out_x      (src_x),
        .out_y      (src_y),
        .out_status (map_status)
    );

    assign m_tdata = {src_y, src_x};
    assign m_tuser = map_status;

    // No word may enter while the coefficients are being derived.
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> !coef_busy)
        else $error("input accepted while coefficients are being derived");

    // A corner write blocks input on the following cycle.
    a_cfg_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready && (cfg_index <= REG_C3Y) |=> !s_tready)
        else $error("input not blocked after a corner write");

    // A degenerate result carries zero coordinates.
    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == STATUS_DEGEN) |-> (src_x == '0) && (src_y == '0))
        else $error("degenerate result with nonzero coordinates");

    // A saturated result has at least one coordinate at a range bound.
    a_sat_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == STATUS_SAT) |->
            (src_x == 32'h7FFF_FFFF) || (src_x == 32'h8000_0000) ||
            (src_y == 32'h7FFF_FFFF) || (src_y == 32'h8000_0000))
        else $error("saturated result without a clamped coordinate");

    // The status code never takes the unused value.
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser != 2'd3))
        else $error("unused status code on output");

endmodule

`default_nettype wire

// File: dv/quad_perspective_coordinate_map_tb.sv
// Self-checking testbench for the quad perspective coordinate map.
// Drives corner settings and (u,v) words and compares each result against an internal
// exact-integer homography predictor. Depends on qpcm_pkg and the RTL top level.
`timescale 1ns / 1ps

module quad_perspective_coordinate_map_tb;
    import qpcm_pkg::*;

    // Every intermediate term fits comfortably below 130 bits, so 192 bits never wrap.
    typedef logic signed [191:0] wide_t;

    typedef struct packed {
        logic [16:0] u;
        logic [16:0] v;
    } uv_word_t;

    typedef struct packed {
        logic [31:0] src_x;
        logic [31:0] src_y;
        map_status_t status;
    } mapped_point_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0] m_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [COORD_W-1:0] cfg_data = '0;

    quad_perspective_coordinate_map DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Shadow copy of the corner registers, in register index order, reset values first.
    logic signed [31:0] corner_regs [8] = '{0, 0, 65536, 0, 0, 65536, 65536, 65536};

    uv_word_t      pending_words [$];
    mapped_point_t expected_points [$];
    int            error_count = 0;
    int            accepted_words = 0;

    // Rounded quotient, ties away from zero, clamped to 32 bits.
    function automatic logic [31:0] rounded_quotient(input wide_t num, input wide_t den,
                                                     inout logic clamped);
        logic neg;
        logic [191:0] an, ad, q, limit;
        neg = (num < 0) != (den < 0);
        an = (num < 0) ? -num : num;
        ad = (den < 0) ? -den : den;
        q = (2 * an + ad) / (2 * ad);
        limit = neg ? 192'h8000_0000 : 192'h7FFF_FFFF;
        if (q > limit) begin
            clamped = 1'b1;
            q = limit;
        end
        return neg ? 32'(-q) : 32'(q);
    endfunction

    // Projective map of the unit square onto the current corners, everything scaled by det.
    function automatic mapped_point_t project_uv(input logic [16:0] u, input logic [16:0] v);
        wide_t x0, y0, x1, y1, x2, y2, x3, y3, uu, vv;
        wide_t det, g, h, ds, w, a, b, c, d, xn, yn;
        logic clamped;
        mapped_point_t p;
        x0 = corner_regs[0]; y0 = corner_regs[1];
        x1 = corner_regs[2]; y1 = corner_regs[3];
        x2 = corner_regs[4]; y2 = corner_regs[5];
        x3 = corner_regs[6]; y3 = corner_regs[7];
        uu = {175'b0, u};
        vv = {175'b0, v};
        clamped = 1'b0;
        det = (x1 - x3) * (y2 - y3) - (x2 - x3) * (y1 - y3);
        g = (x0 - x1 - x2 + x3) * (y2 - y3) - (x2 - x3) * (y0 - y1 - y2 + y3);
        h = (x1 - x3) * (y0 - y1 - y2 + y3) - (x0 - x1 - x2 + x3) * (y1 - y3);
        ds = det * 65536;
        w = g * uu + h * vv + ds;
        if (det == 0 || w == 0) begin
            p.src_x = '0;
            p.src_y = '0;
            p.status = STATUS_DEGEN;
            return p;
        end
        a = (x1 - x0) * det + g * x1;
        b = (x2 - x0) * det + h * x2;
        c = (y1 - y0) * det + g * y1;
        d = (y2 - y0) * det + h * y2;
        xn = a * uu + b * vv + x0 * ds;
        yn = c * uu + d * vv + y0 * ds;
        p.src_x = rounded_quotient(xn, w, clamped);
        p.src_y = rounded_quotient(yn, w, clamped);
        p.status = clamped ? STATUS_SAT : STATUS_OK;
        return p;
    endfunction

    // Idling: about 36 percent of the time on each side, but none while accepted_words is 400 to 649.
    function automatic logic take_a_break();
        if (accepted_words >= 400 && accepted_words < 650) return 1'b0;
        return $urandom_range(99) < 36;
    endfunction

    // Driver: a word is predicted at the edge where it is accepted, then the next one is
    // offered. Corners never change while words are in flight, so the shadow is current.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_points.push_back(project_uv(s_tdata[16:0], s_tdata[33:17]));
                accepted_words <= accepted_words + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_words.size() > 0 && !take_a_break()) begin
                    uv_word_t w;
                    w = pending_words.pop_front();
                    s_tdata <= {6'b0, w.v, w.u};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: the receiver stalls at random and checks each word against the oldest
    // expectation.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_points.size() == 0) begin
                    $display("%0t: unexpected result word, actual x=%h y=%h status=%0d",
                             $realtime, m_tdata[31:0], m_tdata[63:32], m_tuser);
                    error_count <= error_count + 1;
                end else begin
                    mapped_point_t e;
                    e = expected_points.pop_front();
                    if (m_tdata[31:0] !== e.src_x || m_tdata[63:32] !== e.src_y
                            || m_tuser !== e.status) begin
                        $display("%0t: mismatch, expected x=%h y=%h status=%0d, actual x=%h y=%h status=%0d",
                                 $realtime, e.src_x, e.src_y, e.status,
                                 m_tdata[31:0], m_tdata[63:32], m_tuser);
                        error_count <= error_count + 1;
                    end
                end
            end
            m_tready <= !take_a_break();
        end
    end

    task automatic write_corner(input int idx, input logic [31:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= cfg_reg_t'(idx);
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        corner_regs[idx] = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic set_quad(input logic [31:0] c [8]);
        for (int i = 0; i < 8; i++) write_corner(i, c[i]);
    endtask

    task automatic queue_uv(input int u, input int v);
        uv_word_t w;
        w.u = u[16:0];
        w.v = v[16:0];
        pending_words.push_back(w);
    endtask

    // Mostly positions inside the square, the rest anywhere in the 17-bit field.
    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(9) < 7) queue_uv($urandom_range(65536), $urandom_range(65536));
            else queue_uv($urandom_range(131071), $urandom_range(131071));
        end
    endtask

    // Blocks the caller until every queued word is sent and every expected result is back, then idles.
    task automatic drain();
        while (pending_words.size() > 0 || expected_points.size() > 0 || s_tvalid)
            @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_coord(input logic full_range);
        if (full_range) return $urandom;
        return 32'($signed($urandom_range(2_000_000)) - 1_000_000);
    endfunction

    initial begin
        logic [31:0] q [8];
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset corners give the identity map; walk the field extremes first.
        queue_uv(0, 0);          queue_uv(65536, 0);      queue_uv(0, 65536);
        queue_uv(65536, 65536);  queue_uv(131071, 131071); queue_uv(1, 1);
        queue_uv(32768, 32768);  queue_uv(131071, 0);     queue_uv(0, 131071);
        queue_uv(65535, 1);      queue_uv(43690, 21845);  queue_uv(65537, 65536);
        queue_uv(98303, 76459);
        queue_random(140);
        drain();

        // Fourth corner at (2,2): w vanishes where u + v equals three.
        q = '{0, 0, 65536, 0, 0, 65536, 131072, 131072};
        set_quad(q);
        queue_uv(98304, 98304);  queue_uv(131071, 65537); queue_uv(65536, 131071);
        queue_random(60);
        drain();

        // Fourth corner at (0.5,0.5): the corner determinant is zero.
        q = '{0, 0, 65536, 0, 0, 65536, 32768, 32768};
        set_quad(q);
        queue_uv(0, 0);
        queue_random(40);
        drain();

        // Largest square the registers can hold; extrapolation saturates.
        q = '{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        set_quad(q);
        queue_uv(65536, 65536);  queue_uv(131071, 131071); queue_uv(0, 131071);
        queue_random(60);
        drain();

        // All corners on one point.
        q = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
        set_quad(q);
        queue_random(20);
        drain();

        // Random quads: perturbed squares, free moderate quads and full-range quads.
        for (int p = 0; p < 9; p++) begin
            for (int i = 0; i < 8; i++) begin
                case (p % 3)
                    0: q[i] = 32'((((i == 2 || i == 6) ? 1 : 0) +
                                   ((i == 5 || i == 7) ? 1 : 0)) * 65536 * 4
                                  + $signed($urandom_range(120000)) - 60000);
                    1: q[i] = rand_coord(1'b0);
                    default: q[i] = rand_coord(1'b1);
                endcase
            end
            set_quad(q);
            queue_random(85);
            drain();
        end

        if (error_count == 0 && expected_points.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
